[sv/dltq_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and pointer helpers for the delta-list timer queue.
package dltq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int DELAY_BITS  = 16;
   localparam int HANDLE_BITS = 8;

   typedef logic [PTR_BITS-1:0]    ptr_type;
   typedef logic [CNT_BITS-1:0]    cnt_type;
   typedef logic [DELAY_BITS-1:0]  delay_type;
   typedef logic [HANDLE_BITS-1:0] handle_type;

   typedef struct packed {
      delay_type  delta;
      handle_type handle;
   } entry_type;

   typedef enum logic {
      FUNC_SCHEDULE = 1'b0,
      FUNC_TICK     = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_EXPIRED   = 2'd0,
      STATUS_IMMEDIATE = 2'd1,
      STATUS_DROPPED   = 2'd2
   } status_type;

   // Step a physical slot pointer around the circular store.
   function automatic ptr_type ptr_inc(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

   function automatic ptr_type ptr_dec(input ptr_type p);
      ptr_type r;
      if (p == '0) begin
         r = ptr_type'(QUEUE_DEPTH - 1);
      end else begin
         r = p - ptr_type'(1);
      end
      return r;
   endfunction

endpackage

[sv/dltq_req_if.sv]
`timescale 1ns / 1ps
// Request channel: schedule and tick beats into the timer queue.
interface dltq_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] delay_ticks;
   logic [7:0]  event_handle;

   modport source (output valid, output func, output delay_ticks, output event_handle,
                   input ready);
   modport sink   (input valid, input func, input delay_ticks, input event_handle,
                   output ready);
endinterface

[sv/dltq_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel: expired, immediate and dropped event beats.
interface dltq_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] event_handle_res;
   logic [1:0] status;
   logic       last_of_run;

   modport source (output valid, output event_handle_res, output status,
                   output last_of_run, input ready);
   modport sink   (input valid, input event_handle_res, input status,
                   input last_of_run, output ready);
endinterface

[sv/delta_list_timer_queue_unit.sv]
`timescale 1ns / 1ps
// Schedule with delay zero or into a full queue: ST_EMIT sends the response beat; schedule
// behind every entry: appended at the tail, no response beat; otherwise ST_SHIFT walks the
// entries, one per cycle, then ST_INSERT, ST_FIX. Tick: ST_TICK, then ST_EXPIRE on expiry.
// Throughput: one request at a time; the slot store has a single read and a single write port.
// Reset: synchronous, clears the queue to empty; slot contents stay undefined, no clearing pass.
module delta_list_timer_queue_unit
   import dltq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   dltq_req_if.sink   req_if,
   dltq_rsp_if.source rsp_if
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SHIFT  = 7'b0000010,
      ST_INSERT = 7'b0000100,
      ST_FIX    = 7'b0001000,
      ST_TICK   = 7'b0010000,
      ST_EXPIRE = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   cnt_type    cnt_ff, cnt_in;
   ptr_type    head_ff, head_in;
   ptr_type    tail_ff, tail_in;
   delay_type  total_ff, total_in;
   ptr_type    cur_ff, cur_in;
   ptr_type    wr_ff, wr_in;
   ptr_type    fix_ff, fix_in;
   cnt_type    left_ff, left_in;
   delay_type  sum_ff, sum_in;
   delay_type  saved_sum_ff, saved_sum_in;
   handle_type saved_hdl_ff, saved_hdl_in;
   delay_type  delay_ff, delay_in;
   handle_type hdl_ff, hdl_in;
   status_type stat_ff, stat_in;

   entry_type  mem_ff [QUEUE_DEPTH];
   entry_type  rd_data_ff;
   ptr_type    rd_addr;
   logic       mem_we;
   ptr_type    mem_waddr;
   entry_type  mem_wdata;

   logic       rsp_valid_ff;
   handle_type rsp_hdl_ff;
   status_type rsp_stat_ff;
   logic       rsp_last_ff;

   logic       out_free;
   logic       accept;
   logic       emit;
   handle_type emit_hdl;
   status_type emit_stat;
   logic       emit_last;
   delay_type  sum_next;
   delay_type  tick_delta;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign sum_next     = sum_ff - rd_data_ff.delta;
   assign tick_delta   = rd_data_ff.delta - {{(DELAY_BITS-1){1'b0}}, (rd_data_ff.delta != '0)};

   // Insert walk reads behind the cursor, tick and expiry read at the head.
   assign rd_addr = ((state_ff == ST_SHIFT) ||
                     ((state_ff == ST_IDLE) && (req_if.func == FUNC_SCHEDULE))) ? cur_in
                                                                                : head_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      total_in     = total_ff;
      cur_in       = cur_ff;
      wr_in        = wr_ff;
      fix_in       = fix_ff;
      left_in      = left_ff;
      sum_in       = sum_ff;
      saved_sum_in = saved_sum_ff;
      saved_hdl_in = saved_hdl_ff;
      delay_in     = delay_ff;
      hdl_in       = hdl_ff;
      stat_in      = stat_ff;
      mem_we       = 1'b0;
      mem_waddr    = tail_ff;
      mem_wdata    = '0;
      emit         = 1'b0;
      emit_hdl     = hdl_ff;
      emit_stat    = STATUS_EXPIRED;
      emit_last    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.func == FUNC_TICK) begin
                  if (cnt_ff != '0) begin
                     state_in = ST_TICK;
                  end
               end else if (req_if.delay_ticks == '0) begin
                  hdl_in   = req_if.event_handle;
                  stat_in  = STATUS_IMMEDIATE;
                  state_in = ST_EMIT;
               end else if (cnt_ff == cnt_type'(QUEUE_DEPTH)) begin
                  hdl_in   = req_if.event_handle;
                  stat_in  = STATUS_DROPPED;
                  state_in = ST_EMIT;
               end else if (total_ff <= req_if.delay_ticks) begin
                  // Expires after every queued entry: append at the tail.
                  mem_we    = 1'b1;
                  mem_waddr = tail_ff;
                  mem_wdata = '{delta: req_if.delay_ticks - total_ff,
                                handle: req_if.event_handle};
                  tail_in   = ptr_inc(tail_ff);
                  cnt_in    = cnt_ff + cnt_type'(1);
                  total_in  = req_if.delay_ticks;
               end else begin
                  delay_in = req_if.delay_ticks;
                  hdl_in   = req_if.event_handle;
                  sum_in   = total_ff;
                  left_in  = cnt_ff;
                  cur_in   = ptr_dec(tail_ff);
                  wr_in    = tail_ff;
                  state_in = ST_SHIFT;
               end
            end
         end

         ST_SHIFT: begin
            // Move the current entry up one slot and step back.
            mem_we       = 1'b1;
            mem_waddr    = wr_ff;
            mem_wdata    = rd_data_ff;
            fix_in       = wr_ff;
            wr_in        = cur_ff;
            cur_in       = ptr_dec(cur_ff);
            saved_sum_in = sum_ff;
            saved_hdl_in = rd_data_ff.handle;
            sum_in       = sum_next;
            left_in      = left_ff - cnt_type'(1);
            if ((left_ff == cnt_type'(1)) || (sum_next <= delay_ff)) begin
               state_in = ST_INSERT;
            end
         end

         ST_INSERT: begin
            mem_we    = 1'b1;
            mem_waddr = wr_ff;
            mem_wdata = '{delta: delay_ff - sum_ff, handle: hdl_ff};
            tail_in   = ptr_inc(tail_ff);
            cnt_in    = cnt_ff + cnt_type'(1);
            state_in  = ST_FIX;
         end

         ST_FIX: begin
            // Reduce the delta of the entry right behind the new one.
            mem_we    = 1'b1;
            mem_waddr = fix_ff;
            mem_wdata = '{delta: saved_sum_ff - delay_ff, handle: saved_hdl_ff};
            state_in  = ST_IDLE;
         end

         ST_TICK: begin
            if (rd_data_ff.delta != '0) begin
               total_in = total_ff - delay_type'(1);
            end
            if (tick_delta != '0) begin
               mem_we    = 1'b1;
               mem_waddr = head_ff;
               mem_wdata = '{delta: tick_delta, handle: rd_data_ff.handle};
               state_in  = ST_IDLE;
            end else begin
               hdl_in   = rd_data_ff.handle;
               head_in  = ptr_inc(head_ff);
               cnt_in   = cnt_ff - cnt_type'(1);
               state_in = ST_EXPIRE;
            end
         end

         ST_EXPIRE: begin
            if (out_free) begin
               emit = 1'b1;
               if ((cnt_ff == '0) || (rd_data_ff.delta != '0)) begin
                  emit_last = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  // Next entry expires on the same tick: pop it too.
                  emit_last = 1'b0;
                  hdl_in    = rd_data_ff.handle;
                  head_in   = ptr_inc(head_ff);
                  cnt_in    = cnt_ff - cnt_type'(1);
               end
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_stat = stat_ff;
               emit_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      wr_ff        <= wr_in;
      fix_ff       <= fix_in;
      left_ff      <= left_in;
      sum_ff       <= sum_in;
      saved_sum_ff <= saved_sum_in;
      saved_hdl_ff <= saved_hdl_in;
      delay_ff     <= delay_in;
      hdl_ff       <= hdl_in;
      stat_ff      <= stat_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_hdl_ff  <= emit_hdl;
         rsp_stat_ff <= emit_stat;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.event_handle_res = rsp_hdl_ff;
   assign rsp_if.status           = rsp_stat_ff;
   assign rsp_if.last_of_run      = rsp_last_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= cnt_type'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (total_ff == '0))
      else $error("empty queue with nonzero total delay");

   a_shift_needed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> ((sum_ff > delay_ff) && (left_ff != '0)))
      else $error("shift step on an entry that expires before the new one");

   a_expire_pops: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_TICK) && (tick_delta == '0)) |=> (state_ff == ST_EXPIRE))
      else $error("expiring tick did not enter the expiry run");
`endif

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the delta-list timer queue: directed rows, then random traffic.
module tb;
   import dltq_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_ITEMS = 300;

   typedef struct {
      handle_type handle;
      status_type status;
      logic       is_last;
   } beat_type;

   typedef struct {
      func_type   func;
      delay_type  delay;
      handle_type handle;
      bit         typed;
      handle_type want_handle;
      status_type want_status;
   } stim_row_type;

   logic clock;
   logic reset;

   dltq_req_if req_bus ();
   dltq_rsp_if rsp_bus ();

   delta_list_timer_queue_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // timer queue mirror
   delay_type  slot_delta [QUEUE_DEPTH];
   handle_type slot_handle [QUEUE_DEPTH];
   int         live_count;

   beat_type fresh_beats [$];
   beat_type due_beats [$];
   int       error_count;
   int       quiet_cycles;
   bit       tx_burst;
   bit       rx_burst;

   stim_row_type directed_rows [25] = '{
      '{FUNC_TICK,     16'h0000, 8'h00, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'h0000, 8'hFF, 1'b1, 8'hFF, STATUS_IMMEDIATE},
      '{FUNC_SCHEDULE, 16'h0000, 8'h00, 1'b1, 8'h00, STATUS_IMMEDIATE},
      '{FUNC_SCHEDULE, 16'hFFFF, 8'hA5, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd3,    8'h01, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd3,    8'h02, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd1,    8'h03, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd2,    8'h04, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd3,    8'h05, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd5,    8'h10, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd5,    8'h11, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd6,    8'h12, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd8,    8'h13, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd10,   8'h14, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd12,   8'h15, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd20,   8'h16, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd100,  8'h17, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd1000, 8'h18, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd4,    8'h19, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_SCHEDULE, 16'd7,    8'h5A, 1'b1, 8'h5A, STATUS_DROPPED},
      '{FUNC_SCHEDULE, 16'h0000, 8'h3C, 1'b1, 8'h3C, STATUS_IMMEDIATE},
      '{FUNC_TICK,     16'hFFFF, 8'hFF, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_TICK,     16'h0000, 8'h00, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_TICK,     16'h1234, 8'h77, 1'b0, 8'h00, STATUS_EXPIRED},
      '{FUNC_TICK,     16'h0001, 8'h80, 1'b0, 8'h00, STATUS_EXPIRED}
   };

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = ~clock;
   end

   // Apply one schedule or tick to the mirror; the beats it causes land in fresh_beats.
   function automatic void advance_timer_model(func_type f, delay_type d, handle_type h);
      int        sum;
      int        pos;
      int        n;
      int        i;
      delay_type nd;
      fresh_beats.delete();
      if (f == FUNC_SCHEDULE) begin
         if (d == '0) begin
            fresh_beats.push_back('{h, STATUS_IMMEDIATE, 1'b1});
         end else if (live_count >= QUEUE_DEPTH) begin
            fresh_beats.push_back('{h, STATUS_DROPPED, 1'b1});
         end else begin
            sum = 0;
            pos = 0;
            // equal expiry goes behind older entries
            while (pos < live_count && sum + int'(slot_delta[pos]) <= int'(d)) begin
               sum += int'(slot_delta[pos]);
               pos++;
            end
            nd = delay_type'(int'(d) - sum);
            for (i = live_count; i > pos; i--) begin
               slot_delta[i]  = slot_delta[i-1];
               slot_handle[i] = slot_handle[i-1];
            end
            slot_delta[pos]  = nd;
            slot_handle[pos] = h;
            live_count++;
            if (pos + 1 < live_count) begin
               slot_delta[pos+1] = slot_delta[pos+1] - nd;
            end
         end
      end else begin
         if (live_count == 0) begin
            return;
         end
         if (slot_delta[0] != '0) begin
            slot_delta[0] = slot_delta[0] - delay_type'(1);
         end
         if (slot_delta[0] != '0) begin
            return;
         end
         n = 1;
         while (n < live_count && slot_delta[n] == '0) begin
            n++;
         end
         for (i = 0; i < n; i++) begin
            fresh_beats.push_back('{slot_handle[i], STATUS_EXPIRED, (i == n - 1)});
         end
         for (i = 0; i + n < live_count; i++) begin
            slot_delta[i]  = slot_delta[i+n];
            slot_handle[i] = slot_handle[i+n];
         end
         live_count -= n;
      end
   endfunction

   // Drive one request beat after a random gap and hold it until accepted.
   task automatic send_request(func_type f, delay_type d, handle_type h);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= f;
      req_bus.delay_ticks  <= d;
      req_bus.event_handle <= h;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   initial begin
      func_type   f;
      delay_type  d;
      handle_type h;
      int         kind;
      int         idx;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.func         <= FUNC_SCHEDULE;
      req_bus.delay_ticks  <= '0;
      req_bus.event_handle <= '0;
      live_count  = 0;
      error_count = 0;
      tx_burst    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         send_request(directed_rows[r].func, directed_rows[r].delay, directed_rows[r].handle);
         advance_timer_model(directed_rows[r].func, directed_rows[r].delay,
                             directed_rows[r].handle);
         if (directed_rows[r].typed) begin
            due_beats.push_back('{directed_rows[r].want_handle, directed_rows[r].want_status,
                                  1'b1});
         end else begin
            foreach (fresh_beats[k]) due_beats.push_back(fresh_beats[k]);
         end
      end

      for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
         if (idx % 20 == 0) begin
            tx_burst = ($urandom_range(0, 3) == 0);
         end
         // hold off until the queue has drained every pending beat
         if (idx == RANDOM_ITEMS / 2) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (due_beats.size() != 0);
         end
         kind = $urandom_range(0, 99);
         d    = delay_type'($urandom_range(0, 65535));
         h    = handle_type'($urandom_range(0, 255));
         if (kind < 45) begin
            f = FUNC_TICK;
         end else begin
            f = FUNC_SCHEDULE;
            if (kind < 52) begin
               d = '0;
            end else if (kind < 53) begin
               d = ($urandom_range(0, 1) == 1) ? 16'hFFFF : d;
            end else if (kind < 60) begin
               d = delay_type'($urandom_range(20, 400));
            end else begin
               d = delay_type'($urandom_range(1, 20));
            end
         end
         send_request(f, d, h);
         advance_timer_model(f, d, h);
         foreach (fresh_beats[k]) due_beats.push_back(fresh_beats[k]);
      end
      req_bus.valid <= 1'b0;

      do @(posedge clock); while (due_beats.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // Compare one accepted result beat with the oldest pending one.
   task automatic check_beat();
      beat_type want;
      if (due_beats.size() == 0) begin
         $display("%0t: unexpected beat expected none actual handle=%0h status=%0d last=%0b",
                  $time, rsp_bus.event_handle_res, rsp_bus.status, rsp_bus.last_of_run);
         error_count++;
      end else begin
         want = due_beats.pop_front();
         if (rsp_bus.event_handle_res !== want.handle) begin
            $display("%0t: handle mismatch expected %0h actual %0h",
                     $time, want.handle, rsp_bus.event_handle_res);
            error_count++;
         end
         if (rsp_bus.status !== want.status) begin
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, want.status, rsp_bus.status);
            error_count++;
         end
         if (rsp_bus.last_of_run !== want.is_last) begin
            $display("%0t: last_of_run mismatch expected %0b actual %0b",
                     $time, want.is_last, rsp_bus.last_of_run);
            error_count++;
         end
      end
   endtask

   initial begin
      int stall;
      int beats;
      rsp_bus.ready <= 1'b0;
      rx_burst = 1'b0;
      beats    = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (beats % 16 == 0) begin
            rx_burst = ($urandom_range(0, 3) == 0);
         end
         stall = rx_burst ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         check_beat();
         beats++;
      end
   end

   // End the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
         $display("tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
